/* hw/rtl/mrhs_pkg.sv */
// Shared types, constants and the CRC step for the Modbus RTU holding register slave.
`timescale 1ns / 1ps
`default_nettype none
package mrhs_pkg;

  localparam int REG_COUNT   = 16;
  localparam int FRAME_BYTES = 264;

  localparam int RIDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int QTY_W   = $clog2(REG_COUNT + 1);
  localparam int FILL_W  = $clog2(FRAME_BYTES + 1);
  localparam int FADDR_W = $clog2(FRAME_BYTES);

  localparam logic [1:0]  REG_SLAVE_ADDR  = 2'd0;

  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam int          WR_DATA_BASE    = 7;
  localparam logic [2:0]  HEAD_END_READ   = 3'd2;
  localparam logic [2:0]  HEAD_END_WRITE  = 3'd5;

  typedef enum logic [3:0] {
    PH_ADDR, PH_FUNC, PH_START_HI, PH_START_LO, PH_QTY_HI, PH_QTY_LO,
    PH_VAL_HI, PH_VAL_LO, PH_BCOUNT, PH_PAYLOAD, PH_CHK1, PH_CHK2
  } phase_e;

  typedef enum logic [2:0] {
    ST_RX, ST_WR_A, ST_WR_B, ST_WR_C, ST_TX
  } ctrl_state_e;

  typedef enum logic [1:0] {
    TX_HEAD, TX_DATA, TX_CRC_LO, TX_CRC_HI
  } tx_sel_e;

  typedef struct packed {
    logic   rx_accept;
    phase_e phase;
    logic   restart;
    logic   exec_start;
    logic   wr_single;
    logic   rd_issue;
    logic   cap_hi;
    logic   commit;
    logic   tx_load;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic func_single;
    logic func_multi;
    logic byte_zero;
    logic payload_done;
    logic frame_ok;
    logic qty_zero;
    logic wr_last;
    logic tx_last;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/modbus_rtu_holding_register_slave.sv */
// Top level of the Modbus RTU holding register slave with its APB configuration port.
//
// Usage: request bytes enter on rx_byte_i with a valid/ready handshake, one byte per
// beat. Response bytes leave on tx_byte_o / tx_last_o with a valid/ready handshake;
// tx_last_o marks the final byte of each response frame. The slave address is
// written through the APB port (register 0 at byte address 0, reset value 1).
// After the final check byte of a good frame, a write-multiple request reads two
// frame RAM bytes and writes the register file for each register, then the
// response goes out at one byte per cycle while the receiver takes it: the output
// register moves one byte per beat. rx_ready_o stays low from the last check
// byte until the final response byte has been loaded into the output register.
// Reset clears the parser, the register file and the output valid flag.
// A stalled receiver holds the current byte and pauses the response in place.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_holding_register_slave (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  output logic      [7:0]  tx_byte_o,
  output logic             tx_last_o,
  output logic             tx_valid_o,
  input  wire logic        tx_ready_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [7:0]      slave_addr_q;
  mrhs_pkg::cmd_t  cmd;
  mrhs_pkg::stat_t stat;

  assign pready = 1'b1;
  assign prdata = {24'h000000, slave_addr_q};

  // The slave address register sits at byte address 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'h01;
    end else if (psel && penable && pwrite && (paddr == mrhs_pkg::REG_SLAVE_ADDR)) begin
      slave_addr_q <= pwdata[7:0];
    end
  end

  mrhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mrhs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .slave_addr_i (slave_addr_q),
    .rx_byte_i    (rx_byte_i),
    .tx_ready_i   (tx_ready_i),
    .tx_byte_o    (tx_byte_o),
    .tx_last_o    (tx_last_o),
    .tx_valid_o   (tx_valid_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/mrhs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 264
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/mrhs_datapath.sv */
// Datapath: frame capture, CRC, register file, write loop and response byte generation.
`timescale 1ns / 1ps
`default_nettype none
module mrhs_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mrhs_pkg::cmd_t cmd_i,
  output mrhs_pkg::stat_t     stat_o,
  input  wire logic [7:0]     slave_addr_i,
  input  wire logic [7:0]     rx_byte_i,
  input  wire logic           tx_ready_i,
  output logic      [7:0]     tx_byte_o,
  output logic                tx_last_o,
  output logic                tx_valid_o
);

  logic [mrhs_pkg::FILL_W-1:0]  fill_q;
  logic [7:0]                   fcode_q, pcount_q, seen_q, chk_hi_q, byte0_q;
  logic [15:0]                  crc_q, start_q, qty_q, tx_crc_q;
  logic [15:0]                  regs_q [mrhs_pkg::REG_COUNT];
  logic [mrhs_pkg::RIDX_W-1:0]  ptr_q;
  logic [mrhs_pkg::QTY_W-1:0]   rem_q;
  logic [2:0]                   hidx_q;
  mrhs_pkg::tx_sel_e            sel_q;
  logic                         data_hi_q;
  logic [mrhs_pkg::FADDR_W-1:0] wr_addr_q;
  logic                         rd_ok_q;
  logic [7:0]                   hi_byte_q;
  logic [7:0]                   ram_rdata;
  logic [7:0]                   rd_byte;
  logic                         tx_valid_q;

  logic        is_read, func_ok, range_ok, store;
  logic [16:0] range_sum;
  logic [7:0]  head_byte, next_byte;
  logic [15:0] cur_reg;

  assign is_read   = (fcode_q == mrhs_pkg::FC_READ_HOLDING);
  assign func_ok   = (rx_byte_i == mrhs_pkg::FC_READ_HOLDING) ||
                     (rx_byte_i == mrhs_pkg::FC_WRITE_SINGLE) ||
                     (rx_byte_i == mrhs_pkg::FC_WRITE_MULTI);
  assign range_sum = {1'b0, start_q} + {1'b0, qty_q};
  assign range_ok  = (fcode_q == mrhs_pkg::FC_WRITE_SINGLE) ?
                     (start_q < 16'(mrhs_pkg::REG_COUNT)) :
                     (range_sum <= 17'(mrhs_pkg::REG_COUNT));
  assign rd_byte   = rd_ok_q ? ram_rdata : 8'h00;
  assign cur_reg   = regs_q[ptr_q];

  always_comb begin
    stat_o.drop = ((cmd_i.phase == mrhs_pkg::PH_ADDR) && (rx_byte_i != slave_addr_i)) ||
                  ((cmd_i.phase == mrhs_pkg::PH_FUNC) && !func_ok) ||
                  (fill_q >= mrhs_pkg::FILL_W'(mrhs_pkg::FRAME_BYTES));
    stat_o.func_single  = (fcode_q == mrhs_pkg::FC_WRITE_SINGLE);
    stat_o.func_multi   = (fcode_q == mrhs_pkg::FC_WRITE_MULTI);
    stat_o.byte_zero    = (rx_byte_i == 8'h00);
    stat_o.payload_done = ({1'b0, seen_q} + 9'd1) >= {1'b0, pcount_q};
    stat_o.frame_ok     = (crc_q == {rx_byte_i, chk_hi_q}) &&
                          (byte0_q == slave_addr_i) && range_ok;
    stat_o.qty_zero     = (qty_q == 16'h0000);
    stat_o.wr_last      = (rem_q == mrhs_pkg::QTY_W'(1));
    stat_o.tx_last      = (sel_q == mrhs_pkg::TX_CRC_HI);
    stat_o.out_free     = !tx_valid_q || tx_ready_i;
  end

  always_comb begin
    case (hidx_q)
      3'd0:    head_byte = byte0_q;
      3'd1:    head_byte = fcode_q;
      3'd2:    head_byte = is_read ? {qty_q[6:0], 1'b0} : start_q[15:8];
      3'd3:    head_byte = start_q[7:0];
      3'd4:    head_byte = qty_q[15:8];
      default: head_byte = qty_q[7:0];
    endcase
  end

  always_comb begin
    case (sel_q)
      mrhs_pkg::TX_HEAD:   next_byte = head_byte;
      mrhs_pkg::TX_DATA:   next_byte = data_hi_q ? cur_reg[15:8] : cur_reg[7:0];
      mrhs_pkg::TX_CRC_LO: next_byte = tx_crc_q[7:0];
      default:             next_byte = tx_crc_q[15:8];
    endcase
  end

  assign store = cmd_i.rx_accept && !stat_o.drop;

  mrhs_ram #(
    .WIDTH (8),
    .DEPTH (mrhs_pkg::FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (fill_q[mrhs_pkg::FADDR_W-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (wr_addr_q),
    .rdata_o (ram_rdata)
  );

  // Frame parsing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      fcode_q  <= '0;
      pcount_q <= '0;
      seen_q   <= '0;
      crc_q    <= '0;
      chk_hi_q <= '0;
    end else begin
      if (store) begin
        fill_q <= fill_q + 1'b1;
        if (cmd_i.phase == mrhs_pkg::PH_ADDR) begin
          crc_q <= mrhs_pkg::crc_byte(mrhs_pkg::CRC_INIT, rx_byte_i);
        end else if (cmd_i.phase < mrhs_pkg::PH_CHK1) begin
          crc_q <= mrhs_pkg::crc_byte(crc_q, rx_byte_i);
        end
        case (cmd_i.phase)
          mrhs_pkg::PH_FUNC:    fcode_q <= rx_byte_i;
          mrhs_pkg::PH_BCOUNT: begin
            pcount_q <= rx_byte_i;
            seen_q   <= '0;
          end
          mrhs_pkg::PH_PAYLOAD: seen_q <= seen_q + 8'd1;
          mrhs_pkg::PH_CHK1:    chk_hi_q <= rx_byte_i;
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        fill_q   <= '0;
        fcode_q  <= '0;
        pcount_q <= '0;
        seen_q   <= '0;
        crc_q    <= '0;
        chk_hi_q <= '0;
      end
    end
  end

  // Header fields; always rewritten before a frame can execute.
  always_ff @(posedge clk_i) begin
    if (store) begin
      case (cmd_i.phase)
        mrhs_pkg::PH_ADDR:     byte0_q        <= rx_byte_i;
        mrhs_pkg::PH_START_HI: start_q[15:8]  <= rx_byte_i;
        mrhs_pkg::PH_START_LO: start_q[7:0]   <= rx_byte_i;
        mrhs_pkg::PH_QTY_HI:   qty_q[15:8]    <= rx_byte_i;
        mrhs_pkg::PH_QTY_LO:   qty_q[7:0]     <= rx_byte_i;
        mrhs_pkg::PH_VAL_HI:   qty_q[15:8]    <= rx_byte_i;
        mrhs_pkg::PH_VAL_LO:   qty_q[7:0]     <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // Execution counters and response sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      rem_q      <= '0;
      hidx_q     <= '0;
      sel_q      <= mrhs_pkg::TX_HEAD;
      data_hi_q  <= 1'b1;
      tx_crc_q   <= mrhs_pkg::CRC_INIT;
      wr_addr_q  <= '0;
      rd_ok_q    <= 1'b0;
      tx_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec_start) begin
        ptr_q     <= start_q[mrhs_pkg::RIDX_W-1:0];
        rem_q     <= qty_q[mrhs_pkg::QTY_W-1:0];
        hidx_q    <= '0;
        sel_q     <= mrhs_pkg::TX_HEAD;
        data_hi_q <= 1'b1;
        tx_crc_q  <= mrhs_pkg::CRC_INIT;
        wr_addr_q <= mrhs_pkg::FADDR_W'(mrhs_pkg::WR_DATA_BASE);
      end
      if (cmd_i.rd_issue) begin
        wr_addr_q <= wr_addr_q + 1'b1;
        // Bytes past the end of the received frame read as zero.
        rd_ok_q   <= (mrhs_pkg::FILL_W'(wr_addr_q) < fill_q);
      end
      if (cmd_i.commit) begin
        ptr_q <= ptr_q + 1'b1;
        rem_q <= rem_q - 1'b1;
      end
      if (cmd_i.tx_load) begin
        tx_valid_q <= 1'b1;
        case (sel_q)
          mrhs_pkg::TX_HEAD: begin
            tx_crc_q <= mrhs_pkg::crc_byte(tx_crc_q, next_byte);
            hidx_q   <= hidx_q + 3'd1;
            if (hidx_q == (is_read ? mrhs_pkg::HEAD_END_READ : mrhs_pkg::HEAD_END_WRITE)) begin
              sel_q <= (is_read && (rem_q != '0)) ? mrhs_pkg::TX_DATA : mrhs_pkg::TX_CRC_LO;
            end
          end
          mrhs_pkg::TX_DATA: begin
            tx_crc_q  <= mrhs_pkg::crc_byte(tx_crc_q, next_byte);
            data_hi_q <= !data_hi_q;
            if (!data_hi_q) begin
              ptr_q <= ptr_q + 1'b1;
              rem_q <= rem_q - 1'b1;
              if (rem_q == mrhs_pkg::QTY_W'(1)) begin
                sel_q <= mrhs_pkg::TX_CRC_LO;
              end
            end
          end
          mrhs_pkg::TX_CRC_LO: sel_q <= mrhs_pkg::TX_CRC_HI;
          default: ;
        endcase
      end else if (tx_ready_i) begin
        tx_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hi) begin
      hi_byte_q <= rd_byte;
    end
    if (cmd_i.tx_load) begin
      tx_byte_o <= next_byte;
      tx_last_o <= (sel_q == mrhs_pkg::TX_CRC_HI);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mrhs_pkg::REG_COUNT; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cmd_i.wr_single) begin
      regs_q[start_q[mrhs_pkg::RIDX_W-1:0]] <= qty_q;
    end else if (cmd_i.commit) begin
      regs_q[ptr_q] <= {hi_byte_q, rd_byte};
    end
  end

  assign tx_valid_o = tx_valid_q;

endmodule
`default_nettype wire

/* hw/rtl/mrhs_ctrl.sv */
// Controller: parse phase tracking and the execute / response state machine.
`timescale 1ns / 1ps
`default_nettype none
module mrhs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rx_valid_i,
  output logic                 rx_ready_o,
  input  wire mrhs_pkg::stat_t stat_i,
  output mrhs_pkg::cmd_t       cmd_o
);

  mrhs_pkg::ctrl_state_e state_q, state_d;
  mrhs_pkg::phase_e      phase_q, phase_d;
  logic                  accept;

  assign rx_ready_o = (state_q == mrhs_pkg::ST_RX);
  assign accept     = rx_ready_o && rx_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrhs_pkg::ST_RX;
      phase_q <= mrhs_pkg::PH_ADDR;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Next state and next parse phase.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      mrhs_pkg::ST_RX: begin
        if (accept) begin
          if (stat_i.drop) begin
            phase_d = mrhs_pkg::PH_ADDR;
          end else begin
            case (phase_q)
              mrhs_pkg::PH_ADDR:     phase_d = mrhs_pkg::PH_FUNC;
              mrhs_pkg::PH_FUNC:     phase_d = mrhs_pkg::PH_START_HI;
              mrhs_pkg::PH_START_HI: phase_d = mrhs_pkg::PH_START_LO;
              mrhs_pkg::PH_START_LO:
                phase_d = stat_i.func_single ? mrhs_pkg::PH_VAL_HI : mrhs_pkg::PH_QTY_HI;
              mrhs_pkg::PH_QTY_HI:   phase_d = mrhs_pkg::PH_QTY_LO;
              mrhs_pkg::PH_QTY_LO:
                phase_d = stat_i.func_multi ? mrhs_pkg::PH_BCOUNT : mrhs_pkg::PH_CHK1;
              mrhs_pkg::PH_VAL_HI:   phase_d = mrhs_pkg::PH_VAL_LO;
              mrhs_pkg::PH_VAL_LO:   phase_d = mrhs_pkg::PH_CHK1;
              mrhs_pkg::PH_BCOUNT:
                phase_d = stat_i.byte_zero ? mrhs_pkg::PH_CHK1 : mrhs_pkg::PH_PAYLOAD;
              mrhs_pkg::PH_PAYLOAD:
                phase_d = stat_i.payload_done ? mrhs_pkg::PH_CHK1 : mrhs_pkg::PH_PAYLOAD;
              mrhs_pkg::PH_CHK1:     phase_d = mrhs_pkg::PH_CHK2;
              mrhs_pkg::PH_CHK2: begin
                phase_d = mrhs_pkg::PH_ADDR;
                if (stat_i.frame_ok) begin
                  state_d = (stat_i.func_multi && !stat_i.qty_zero) ?
                            mrhs_pkg::ST_WR_A : mrhs_pkg::ST_TX;
                end
              end
              default: phase_d = mrhs_pkg::PH_ADDR;
            endcase
          end
        end
      end
      mrhs_pkg::ST_WR_A: state_d = mrhs_pkg::ST_WR_B;
      mrhs_pkg::ST_WR_B: state_d = mrhs_pkg::ST_WR_C;
      mrhs_pkg::ST_WR_C: state_d = stat_i.wr_last ? mrhs_pkg::ST_TX : mrhs_pkg::ST_WR_A;
      mrhs_pkg::ST_TX: begin
        if (stat_i.out_free && stat_i.tx_last) begin
          state_d = mrhs_pkg::ST_RX;
        end
      end
      default: state_d = mrhs_pkg::ST_RX;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.rx_accept  = accept;
    cmd_o.phase      = phase_q;
    case (state_q)
      mrhs_pkg::ST_RX: begin
        if (accept) begin
          if (stat_i.drop) begin
            cmd_o.restart = 1'b1;
          end else if (phase_q == mrhs_pkg::PH_CHK2) begin
            if (stat_i.frame_ok) begin
              cmd_o.exec_start = 1'b1;
              cmd_o.wr_single  = stat_i.func_single;
            end else begin
              cmd_o.restart = 1'b1;
            end
          end else if (phase_q > mrhs_pkg::PH_CHK2) begin
            cmd_o.restart = 1'b1;
          end
        end
      end
      mrhs_pkg::ST_WR_A: cmd_o.rd_issue = 1'b1;
      mrhs_pkg::ST_WR_B: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.cap_hi   = 1'b1;
      end
      mrhs_pkg::ST_WR_C: cmd_o.commit = 1'b1;
      mrhs_pkg::ST_TX: begin
        cmd_o.tx_load = stat_i.out_free;
        cmd_o.restart = stat_i.out_free && stat_i.tx_last;
      end
      default: ;
    endcase
  end

  // A response byte is only loaded into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tx_load |-> stat_i.out_free)
    else $error("response byte loaded over a pending beat");

  // No request byte is taken while a frame executes or its response drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mrhs_pkg::ST_RX) |-> !cmd_o.rx_accept)
    else $error("request byte accepted during execution");

  // Every restart leaves the parser waiting for an address byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.restart |=> (phase_q == mrhs_pkg::PH_ADDR))
    else $error("parser not at address phase after restart");

  // The write loop only runs for a write-multiple request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrhs_pkg::ST_WR_A) |-> stat_i.func_multi)
    else $error("write loop entered for wrong function");

endmodule
`default_nettype wire

/* test/modbus_rtu_holding_register_slave_chk.sv */
// Checker for the Modbus RTU holding register slave: predicts response bytes and compares.
`timescale 1ns / 1ps
module modbus_rtu_holding_register_slave_chk (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        rx_valid_i,
  input  wire logic        rx_ready_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic        tx_last_i,
  input  wire logic        tx_valid_i,
  input  wire logic        tx_ready_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [1:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic        pready_i,
  output int               pending_o,
  output int               errors_o
);

  logic [7:0]       my_address;
  mrhs_pkg::phase_e phase;
  logic [7:0]       frame_mem [mrhs_pkg::FRAME_BYTES];
  int               fill;
  logic [7:0]       func;
  logic [7:0]       pay_count;
  logic [7:0]       pay_seen;
  logic [15:0]      run_crc;
  logic [7:0]       crc_first;
  logic [15:0]      regs [mrhs_pkg::REG_COUNT];

  logic [7:0]  resp_bytes [$];
  logic        resp_lasts [$];

  assign pending_o = resp_bytes.size();

  function automatic logic [15:0] crc16_modbus(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {8'h00, d};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors_o++;
  endtask

  task automatic clear_parser();
    phase = mrhs_pkg::PH_ADDR;
    for (int i = 0; i < mrhs_pkg::FRAME_BYTES; i++) frame_mem[i] = 8'h00;
    fill = 0;
    func = 8'h00;
    pay_count = 8'h00;
    pay_seen = 8'h00;
    run_crc = 16'h0000;
    crc_first = 8'h00;
  endtask

  function automatic logic [7:0] fbyte(input int i);
    return (i < mrhs_pkg::FRAME_BYTES) ? frame_mem[i] : 8'h00;
  endfunction

  // Executes a frame whose check bytes matched and queues the response bytes.
  task automatic run_request();
    logic [7:0]  resp [$];
    int          start, qty;
    logic [15:0] c;
    bit          add_crc;
    start = {fbyte(2), fbyte(3)};
    qty = {fbyte(4), fbyte(5)};
    add_crc = 1'b1;
    if (fbyte(0) != my_address) return;
    if (func == mrhs_pkg::FC_READ_HOLDING) begin
      if (start + qty > mrhs_pkg::REG_COUNT) return;
      resp.push_back(fbyte(0));
      resp.push_back(mrhs_pkg::FC_READ_HOLDING);
      resp.push_back(8'((qty * 2) & 8'hFF));
      for (int i = 0; i < qty; i++) begin
        resp.push_back(regs[start + i][15:8]);
        resp.push_back(regs[start + i][7:0]);
      end
    end else if (func == mrhs_pkg::FC_WRITE_SINGLE) begin
      if (start >= mrhs_pkg::REG_COUNT) return;
      regs[start] = 16'(qty);
      for (int i = 0; i < 8; i++) resp.push_back(fbyte(i));
      add_crc = 1'b0;
    end else if (func == mrhs_pkg::FC_WRITE_MULTI) begin
      if (start + qty > mrhs_pkg::REG_COUNT) return;
      for (int i = 0; i < qty; i++) regs[start + i] = {fbyte(7 + 2 * i), fbyte(8 + 2 * i)};
      for (int i = 0; i < 6; i++) resp.push_back(fbyte(i));
    end else begin
      return;
    end
    if (add_crc) begin
      c = 16'hFFFF;
      foreach (resp[i]) c = crc16_modbus(c, resp[i]);
      resp.push_back(c[7:0]);
      resp.push_back(c[15:8]);
    end
    foreach (resp[i]) begin
      resp_bytes.push_back(resp[i]);
      resp_lasts.push_back(i == resp.size() - 1);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    mrhs_pkg::phase_e ph;
    ph = phase;
    if (ph == mrhs_pkg::PH_ADDR && b != my_address) begin
      clear_parser();
      return;
    end
    if (ph == mrhs_pkg::PH_FUNC && b != mrhs_pkg::FC_READ_HOLDING &&
        b != mrhs_pkg::FC_WRITE_SINGLE && b != mrhs_pkg::FC_WRITE_MULTI) begin
      clear_parser();
      return;
    end
    if (fill >= mrhs_pkg::FRAME_BYTES) begin
      clear_parser();
      return;
    end
    frame_mem[fill] = b;
    fill++;
    if (ph == mrhs_pkg::PH_ADDR) run_crc = crc16_modbus(16'hFFFF, b);
    else if (ph < mrhs_pkg::PH_CHK1) run_crc = crc16_modbus(run_crc, b);
    case (ph)
      mrhs_pkg::PH_ADDR: phase = mrhs_pkg::PH_FUNC;
      mrhs_pkg::PH_FUNC: begin
        func = b;
        phase = mrhs_pkg::PH_START_HI;
      end
      mrhs_pkg::PH_START_HI: phase = mrhs_pkg::PH_START_LO;
      mrhs_pkg::PH_START_LO:
        phase = (func == mrhs_pkg::FC_WRITE_SINGLE) ? mrhs_pkg::PH_VAL_HI : mrhs_pkg::PH_QTY_HI;
      mrhs_pkg::PH_QTY_HI: phase = mrhs_pkg::PH_QTY_LO;
      mrhs_pkg::PH_QTY_LO:
        phase = (func == mrhs_pkg::FC_WRITE_MULTI) ? mrhs_pkg::PH_BCOUNT : mrhs_pkg::PH_CHK1;
      mrhs_pkg::PH_VAL_HI: phase = mrhs_pkg::PH_VAL_LO;
      mrhs_pkg::PH_VAL_LO: phase = mrhs_pkg::PH_CHK1;
      mrhs_pkg::PH_BCOUNT: begin
        pay_count = b;
        pay_seen = 8'h00;
        phase = (b == 8'h00) ? mrhs_pkg::PH_CHK1 : mrhs_pkg::PH_PAYLOAD;
      end
      mrhs_pkg::PH_PAYLOAD: begin
        pay_seen++;
        if (pay_seen >= pay_count) phase = mrhs_pkg::PH_CHK1;
      end
      mrhs_pkg::PH_CHK1: begin
        crc_first = b;
        phase = mrhs_pkg::PH_CHK2;
      end
      default: begin
        if (run_crc == {b, crc_first}) run_request();
        clear_parser();
      end
    endcase
  endtask

  initial begin
    errors_o = 0;
    my_address = 8'd1;
    for (int i = 0; i < mrhs_pkg::REG_COUNT; i++) regs[i] = 16'h0000;
    clear_parser();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == mrhs_pkg::REG_SLAVE_ADDR)
        my_address = pwdata_i[7:0];
      if (rx_valid_i && rx_ready_i) take_byte(rx_byte_i);
      if (tx_valid_i && tx_ready_i) begin
        if (resp_bytes.size() == 0) begin
          report($sformatf("unexpected response beat %02h last %0b", tx_byte_i, tx_last_i));
        end else begin
          if (tx_byte_i !== resp_bytes[0])
            report($sformatf("tx_byte %02h, expected %02h", tx_byte_i, resp_bytes[0]));
          if (tx_last_i !== resp_lasts[0])
            report($sformatf("tx_last %0b, expected %0b", tx_last_i, resp_lasts[0]));
          void'(resp_bytes.pop_front());
          void'(resp_lasts.pop_front());
        end
      end
    end
  end

endmodule

/* test/modbus_rtu_holding_register_slave_tb.sv */
// Testbench top: drives request frames and APB writes into the slave and gives the verdict.
`timescale 1ns / 1ps
module modbus_rtu_holding_register_slave_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 200;
  localparam logic [7:0] FC_UNSUPPORTED = 8'h04;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        tx_valid;
  logic        tx_ready;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending, errors;
  int          cycles = 0;
  bit          calm = 1'b0;
  logic [7:0]  cur_addr = 8'd1;
  logic [7:0]  frame_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  modbus_rtu_holding_register_slave u_top (
    .clk_i, .rst_ni,
    .rx_byte_i(rx_byte), .rx_valid_i(rx_valid), .rx_ready_o(rx_ready),
    .tx_byte_o(tx_byte), .tx_last_o(tx_last), .tx_valid_o(tx_valid), .tx_ready_i(tx_ready),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  modbus_rtu_holding_register_slave_chk u_chk (
    .clk_i, .rst_ni,
    .rx_byte_i(rx_byte), .rx_valid_i(rx_valid), .rx_ready_i(rx_ready),
    .tx_byte_i(tx_byte), .tx_last_i(tx_last), .tx_valid_i(tx_valid), .tx_ready_i(tx_ready),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    tx_ready <= calm || ($urandom_range(0, 99) >= 28);
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit took;
    gap = (!calm && $urandom_range(0, 99) < 28) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do begin
      @(negedge clk_i);
      took = rx_ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic head(input logic [7:0] a, input logic [7:0] fc);
    frame_q.delete();
    frame_q.push_back(a);
    frame_q.push_back(fc);
  endtask

  task automatic add16(input logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  // Appends the check bytes, corrupting them when asked, and sends the frame.
  task automatic close_and_send(input bit corrupt);
    logic [15:0] c;
    c = mrhs_pkg::CRC_INIT;
    foreach (frame_q[i]) c = mrhs_pkg::crc_byte(c, frame_q[i]);
    if (corrupt) c ^= 16'($urandom_range(1, 16'hFFFF));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic read_req(input int start, input int qty, input bit corrupt);
    head(cur_addr, mrhs_pkg::FC_READ_HOLDING);
    add16(16'(start));
    add16(16'(qty));
    close_and_send(corrupt);
  endtask

  task automatic write_one(input int reg_idx, input logic [15:0] v, input bit corrupt);
    head(cur_addr, mrhs_pkg::FC_WRITE_SINGLE);
    add16(16'(reg_idx));
    add16(v);
    close_and_send(corrupt);
  endtask

  task automatic write_many(input int start, input int qty, input int bcount,
                            input bit corrupt);
    head(cur_addr, mrhs_pkg::FC_WRITE_MULTI);
    add16(16'(start));
    add16(16'(qty));
    frame_q.push_back(8'(bcount));
    for (int i = 0; i < bcount; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    close_and_send(corrupt);
  endtask

  task automatic set_address(input logic [7:0] a);
    while (pending != 0) @(posedge clk_i);
    rx_valid <= 1'b0;
    repeat (SETTLE) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= mrhs_pkg::REG_SLAVE_ADDR;
    pwdata <= {24'($urandom), a};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_addr = a;
  endtask

  task automatic random_frame();
    int kind, start, qty;
    kind = $urandom_range(0, 99);
    start = $urandom_range(0, mrhs_pkg::REG_COUNT - 1);
    qty = $urandom_range(0, mrhs_pkg::REG_COUNT - start);
    if ($urandom_range(0, 9) == 0) qty = mrhs_pkg::REG_COUNT - start + $urandom_range(1, 3);
    if (kind < 30) begin
      read_req(start, qty, 1'b0);
    end else if (kind < 50) begin
      write_one(($urandom_range(0, 9) == 0) ?
                $urandom_range(mrhs_pkg::REG_COUNT, 16'hFFFF) : start,
                16'($urandom), 1'b0);
    end else if (kind < 75) begin
      if (qty > 4) qty = $urandom_range(1, 4);
      write_many(start, qty, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * qty) : 2 * qty,
                 1'b0);
    end else if (kind < 83) begin
      read_req(start, qty, 1'b1);
    end else if (kind < 90) begin
      head(cur_addr ^ 8'($urandom_range(1, 255)), mrhs_pkg::FC_READ_HOLDING);
      add16(16'(start));
      add16(16'(qty));
      close_and_send(1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    rx_valid <= 1'b0;
    rx_byte <= 8'h00;
    tx_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 2'd0;
    pwdata <= 32'h0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset address, range edges, the write paths and the dropped frames.
    read_req(0, mrhs_pkg::REG_COUNT, 1'b0);
    write_one(mrhs_pkg::REG_COUNT - 1, 16'hFFFF, 1'b0);
    write_one(mrhs_pkg::REG_COUNT, 16'h1234, 1'b0);
    write_many(mrhs_pkg::REG_COUNT - 4, 4, 8, 1'b0);
    read_req(0, mrhs_pkg::REG_COUNT, 1'b0);
    read_req(3, 0, 1'b0);
    write_many(2, 0, 0, 1'b0);
    write_many(4, 3, 2, 1'b0);
    write_many(1, 2, 4, 1'b1);
    send_byte(8'hFF);
    head(cur_addr, FC_UNSUPPORTED);
    foreach (frame_q[i]) send_byte(frame_q[i]);
    set_address(8'd247);
    read_req(0, 8, 1'b0);
    set_address(8'd0);
    write_one(5, 16'hA5A5, 1'b0);
    set_address(8'd255);
    read_req(4, 4, 1'b0);

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      set_address((phase_no == 0) ? 8'd1 : 8'($urandom_range(1, 247)));
      for (int i = 0; i < 2; i++) begin
        calm = (phase_no == 1);
        random_frame();
      end
    end
    calm = 1'b0;
    rx_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
